[hw/rtl/iopgt_pkg.sv]
// ----------------------------------------------------------------------------
// I/O port grant table package
// Types, codes and default sizes shared by the grant table and its checker.
// ----------------------------------------------------------------------------
package iopgt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int ENV_COUNT_DEF     = 32;

   localparam int PORT_W   = 16;
   localparam int ENV_ID_W = 5;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 3;

   typedef enum logic [0:0] {
      ACT_GRANT  = 1'b0,
      ACT_REVOKE = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_EXCL_REQ   = 3'd2,
      STAT_ENTRY_EXCL = 3'd3,
      STAT_ALREADY    = 3'd4,
      STAT_UNKNOWN    = 3'd5,
      STAT_NOT_HOLDER = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DECIDE
   } state_type;

   typedef struct packed {
      logic                action;
      logic [PORT_W-1:0]   port_number;
      logic                want_exclusive;
      logic [ENV_ID_W-1:0] env_id;
   } req_type;

   typedef struct packed {
      logic       success;
      status_type status;
   } rsp_type;

endpackage

[hw/rtl/iopgt_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered on rd_en.
// ----------------------------------------------------------------------------
module iopgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/io_port_grant_table.sv]
// ----------------------------------------------------------------------------
// I/O port grant table
// Grants and revokes per-environment access to I/O ports, one request a time.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the word is taken at the
//   clock edge where start is high and busy is low. busy stays high until the
//   result is out.
//   Result channel: rsp_data is valid for exactly one cycle with rsp_valid;
//   the receiver cannot stall it and must take it in that cycle.
//   Timing: the table RAM is walked one entry a cycle (registered read, so
//   each compare is made in the cycle after its address). The scan stops at
//   the entry that holds the port, or after the last entry on a miss; then
//   the DECIDE state decides and writes. The result strobe comes the cycle
//   after, and busy is already low then, so a waiting word is taken at the
//   edge that ends the strobe.
//   Reset clears all entry valid bits and the sequencer; entry payload is
//   only looked at while its valid bit is set, so the RAM needs no clearing.
//   env_id values at or above ENV_COUNT are folded modulo ENV_COUNT.
// ----------------------------------------------------------------------------
module io_port_grant_table
   import iopgt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int ENV_COUNT     = ENV_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ENV_W = $clog2(ENV_COUNT);
   localparam int ENV_IDS = 2 ** ENV_ID_W;

   // entry word layout: {port, exclusive, holder set, holder count}
   localparam int CNT_LO  = 0;
   localparam int SET_LO  = CNT_LO + COUNT_W;
   localparam int EXCL_LO = SET_LO + ENV_COUNT;
   localparam int PORT_LO = EXCL_LO + 1;
   localparam int ENT_W   = PORT_LO + PORT_W;

   // sequencer and request
   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // read pipeline: which entry the RAM output belongs to
   logic               pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]   pipe_idx_ff, pipe_idx_in;

   // scan results
   logic               hit_fnd_ff, hit_fnd_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [ENT_W-1:0]   hit_ent_ff, hit_ent_in;
   logic               free_fnd_ff, free_fnd_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // RAM port
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENT_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [ENT_W-1:0]   ram_rd_data;

   // env fold: constant table, env_id -> env_id mod ENV_COUNT
   logic [ENV_W-1:0]     env_mod_tbl [ENV_IDS];
   logic [ENV_W-1:0]     env_idx;
   logic [ENV_COUNT-1:0] env_bit;

   for (genvar g = 0; g < ENV_IDS; g++) begin : g_env_mod
      assign env_mod_tbl[g] = ENV_W'(g % ENV_COUNT);
   end

   assign env_idx = env_mod_tbl[req_ff.env_id];
   assign env_bit = {{(ENV_COUNT-1){1'b0}}, 1'b1} << env_idx;

   // current compare
   logic cur_valid;
   logic scan_hit;

   assign cur_valid = valid_ff[pipe_idx_ff];
   assign scan_hit  = pipe_vld_ff && cur_valid
                      && (ram_rd_data[PORT_LO +: PORT_W] == req_ff.port_number);

   // fields of the matched entry
   logic                 ent_excl;
   logic [ENV_COUNT-1:0] ent_set;
   logic [COUNT_W-1:0]   ent_cnt;

   assign ent_excl = hit_ent_ff[EXCL_LO];
   assign ent_set  = hit_ent_ff[SET_LO +: ENV_COUNT];
   assign ent_cnt  = hit_ent_ff[CNT_LO +: COUNT_W];

   iopgt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pipe_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pipe_vld_ff  <= pipe_vld_in;
      end
      req_ff      <= req_in;
      cnt_ff      <= cnt_in;
      pipe_idx_ff <= pipe_idx_in;
      hit_fnd_ff  <= hit_fnd_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      free_fnd_ff <= free_fnd_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      logic [ENV_COUNT-1:0] new_set;
      logic [COUNT_W-1:0]   new_cnt;
      logic                 new_excl;
      status_type           st;

      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = pipe_idx_ff;
      hit_fnd_in   = hit_fnd_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = hit_idx_ff;
      new_set      = ent_set;
      new_cnt      = ent_cnt;
      new_excl     = ent_excl;
      st           = STAT_OK;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               req_in      = req_data;
               cnt_in      = '0;
               hit_fnd_in  = 1'b0;
               free_fnd_in = 1'b0;
               state_in    = SCAN;
            end
         end

         SCAN: begin
            // issue next read unless the current compare already matched
            ram_rd_en   = (cnt_ff < CNT_W'(TABLE_ENTRIES)) && !scan_hit;
            pipe_vld_in = ram_rd_en;
            pipe_idx_in = cnt_ff[IDX_W-1:0];
            if (ram_rd_en) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            // lowest free entry, kept in case the port is not found
            if (pipe_vld_ff && !cur_valid && !free_fnd_ff) begin
               free_fnd_in = 1'b1;
               free_idx_in = pipe_idx_ff;
            end
            if (scan_hit) begin
               hit_fnd_in = 1'b1;
               hit_idx_in = pipe_idx_ff;
               hit_ent_in = ram_rd_data;
               state_in   = DECIDE;
            end else if (pipe_vld_ff && cnt_ff == CNT_W'(TABLE_ENTRIES)) begin
               state_in = DECIDE;
            end
         end

         DECIDE: begin
            if (req_ff.action == ACT_GRANT) begin
               if (!hit_fnd_ff) begin
                  if (!free_fnd_ff) begin
                     st = STAT_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = free_idx_ff;
                     new_excl    = req_ff.want_exclusive;
                     new_set     = env_bit;
                     new_cnt     = COUNT_W'(1);
                     valid_in[free_idx_ff] = 1'b1;
                  end
               end else if (req_ff.want_exclusive) begin
                  st = STAT_EXCL_REQ;
               end else if (ent_excl) begin
                  st = STAT_ENTRY_EXCL;
               end else if ((ent_set & env_bit) != '0) begin
                  st = STAT_ALREADY;
               end else begin
                  ram_wr_en = 1'b1;
                  new_set   = ent_set | env_bit;
                  new_cnt   = ent_cnt + COUNT_W'(1);
               end
            end else begin
               if (!hit_fnd_ff) begin
                  st = STAT_UNKNOWN;
               end else if ((ent_set & env_bit) == '0) begin
                  st = STAT_NOT_HOLDER;
               end else begin
                  ram_wr_en = 1'b1;
                  new_set   = ent_set & ~env_bit;
                  new_cnt   = ent_cnt - COUNT_W'(1);
                  if (new_set == '0) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end
               end
            end
            rsp_valid_in   = 1'b1;
            rsp_in.success = (st == STAT_OK);
            rsp_in.status  = st;
            state_in       = IDLE;
         end

         default: begin
            state_in = IDLE;
         end
      endcase

      ram_wr_data = {req_ff.port_number, new_excl, new_set, new_cnt};
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/iopgt_chk.sv]
// ----------------------------------------------------------------------------
// I/O port grant table checker
// Port-level timing and result consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
module iopgt_chk
   import iopgt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an accepted word always starts a busy period
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // one strobe per word: never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // result comes out at the end of a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result outside the end of a busy period");

   // success flag agrees with status code
   a_success_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.success == (rsp_data.status == STAT_OK)))
      else $error("success flag disagrees with status");

endmodule

bind io_port_grant_table iopgt_chk u_iopgt_chk (.*);
